[sv/sos_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the segmented odd-only sieve.
// Used by sos_div and segmented_odd_sieve; depends on nothing.
package sos_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_MARK  = 2'd1,
    MODE_PROBE = 2'd2,
    MODE_TRIM  = 2'd3
  } sos_mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SHORT = 2'd1,
    STAT_RANGE = 2'd2
  } sos_stat_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_DIV,
    ST_MRD,
    ST_MCHK,
    ST_PCHK,
    ST_TRD,
    ST_TCHK,
    ST_FIN
  } sos_state_e;

  // Divider result as seen by the controller.
  typedef struct packed {
    logic        done;
    logic        quo_odd;
    logic [31:0] rem;
  } sos_div_res_t;

  localparam logic [31:0] SEG_START_RST = 32'd1;
  localparam logic [12:0] SEG_LEN_RST   = 13'd4096;
  localparam logic        REG_SEG_START = 1'b0;
  localparam logic        REG_SEG_LEN   = 1'b1;

endpackage

[sv/sos_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module sos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[sv/sos_div.sv]
`timescale 1ns / 1ps
// Restoring 32-bit divider, one quotient bit per cycle.
// Depends on sos_pkg for the result struct.
module sos_div
  import sos_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [31:0]  dividend_i,
  input  logic [31:0]  divisor_i,
  output sos_div_res_t res_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] dsr_q;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;

  assign trial = {rem_q, quo_q[31]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = ~diff[32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[31:0] : trial[31:0];
      quo_q <= {quo_q[30:0], fits};
    end
  end

  assign res_o.done    = done_q;
  assign res_o.quo_odd = quo_q[0];
  assign res_o.rem     = rem_q;

endmodule

[sv/segmented_odd_sieve.sv]
`timescale 1ns / 1ps
// Segmented sieve of Eratosthenes over odd numbers, one bitmap bit per entry.
// Depends on sos_pkg, sos_ram and sos_div.
//
// Usage: commands enter on the input channel (mode_i, value_i, end_of_run_i)
// under in_valid_i / in_stall_o; each beat produces exactly one result beat
// on the output channel under out_valid_o / out_stall_i. The user must write
// the segment start and length through the APB port while the block is idle;
// the block does not enforce it. One command is worked on at a time; the
// bitmap is one synchronous RAM of DEPTH one-bit entries, read and written back.
// Steps per command, from acceptance to the result being offered:
//   clear: one RAM entry zeroed per cycle.
//   mark:  the 32-step divider finds the first multiple, then each visited
//          entry is read, then updated, until the final bound check; a
//          zero factor goes straight to the result.
//   probe: the entry is read and checked, unless the index is out of range.
//   trim:  each scanned entry is read, then checked, until the nth unmarked
//          entry is found; a zero count goes straight to the result.
// After reset the block sweeps the whole RAM to zero and keeps in_stall_o
// high meanwhile; APB writes are taken as ever.
// The result waits in an output register; if the receiver stalls, the block
// holds the finished result and takes no new command until it is taken.
module segmented_odd_sieve
  import sos_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] value_i,
  input  logic        end_of_run_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [12:0] prime_count_o,
  output logic [11:0] found_index_o,
  output logic [31:0] found_number_o,
  output logic        is_prime_o,
  output logic        run_done_o,
  output logic [1:0]  status_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam logic [LW-1:0] ACT_RST =
    LW'((DEPTH < int'(SEG_LEN_RST)) ? DEPTH : int'(SEG_LEN_RST));
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // Configuration registers.
  logic [31:0] seg_start_q;
  logic [12:0] seg_len_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_SEG_LEN) ? {19'd0, seg_len_q} : seg_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_start_q <= SEG_START_RST;
      seg_len_q   <= SEG_LEN_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SEG_LEN) begin
        seg_len_q <= pwdata[12:0];
      end else begin
        seg_start_q <= pwdata;
      end
    end
  end

  // Sieve state.
  sos_state_e   state_q, state_d;
  logic [LW-1:0] act_q;      // active length
  logic [LW-1:0] cnt_q;      // unmarked count
  logic [LW-1:0] seen_q;     // unmarked entries passed during a trim
  logic [AW-1:0] sweep_q;
  logic [32:0]   idx_q;      // current bitmap position, may run past the end
  logic [31:0]   val_q;
  logic [1:0]    mode_q;
  logic          eor_q;
  logic [AW-1:0] res_idx_q;
  logic          res_hit_q;
  logic          res_prime_q;
  sos_stat_e     res_stat_q;
  logic          div_go_q;   // start pulse for the divider on entry to the division state

  logic          in_acc;
  logic          out_load;
  logic          sweep_last;
  logic          idx_in;
  logic [LW-1:0] len_clamped;
  logic [32:0]   first_off;
  logic [32:0]   off_diff;

  // RAM and divider wiring.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;
  logic          div_start;
  sos_div_res_t  div_res;

  sos_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_bits (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  sos_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(seg_start_q | 32'd1),
    .divisor_i (val_q),
    .res_o     (div_res)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_load    = (state_q == ST_FIN) & (~out_valid_o | ~out_stall_i);
  assign sweep_last  = (sweep_q == LAST_ADDR);
  assign idx_in      = (idx_q < 33'(act_q));
  assign len_clamped = (32'(seg_len_q) > 32'(DEPTH)) ? LW'(DEPTH) : LW'(seg_len_q);

  // The divider starts in the cycle after a mark beat with a nonzero factor, once val_q is loaded.
  assign div_start = div_go_q;

  // With s = q0*p + r and r nonzero, the first odd multiple past s lies
  // p - r above s when q0 is even and 2p - r above s when q0 is odd.
  assign off_diff  = (div_res.quo_odd ? {val_q, 1'b0} : {1'b0, val_q})
                     - {1'b0, div_res.rem};
  assign first_off = (div_res.rem == 32'd0) ? 33'd0 : {1'b0, off_diff[32:1]};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = 1'b1;
    ram_raddr = (state_q == ST_IDLE) ? value_i[AW-1:0] : idx_q[AW-1:0];
    state_d   = state_q;
    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = 1'b0;
        if (sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (sos_mode_e'(mode_i))
            MODE_CLEAR: state_d = ST_CLR;
            MODE_MARK:  state_d = (value_i == 32'd0) ? ST_FIN : ST_DIV;
            MODE_PROBE: state_d = (value_i >= 32'(act_q)) ? ST_FIN : ST_PCHK;
            MODE_TRIM:  state_d = (value_i == 32'd0) ? ST_FIN : ST_TRD;
            default:    state_d = ST_FIN;
          endcase
        end
      end
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = 1'b0;
        if (sweep_last) begin
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_MRD;
        end
      end
      ST_MRD:  state_d = idx_in ? ST_MCHK : ST_FIN;
      ST_MCHK: begin
        ram_we  = ~ram_rdata;
        state_d = ST_MRD;
      end
      ST_PCHK: state_d = ST_FIN;
      ST_TRD:  state_d = idx_in ? ST_TCHK : ST_FIN;
      ST_TCHK: begin
        if (~ram_rdata && ((32'(seen_q) + 32'd1) == val_q)) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_TRD;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= ACT_RST;
      cnt_q    <= '0;
      sweep_q  <= '0;
      div_go_q <= 1'b0;
    end else begin
      div_go_q <= 1'b0;
      unique case (state_q)
        ST_INIT: sweep_q <= sweep_q + AW'(1);
        ST_IDLE: begin
          sweep_q <= '0;
          if (in_acc && (sos_mode_e'(mode_i) == MODE_MARK) && (value_i != 32'd0)) begin
            div_go_q <= 1'b1;
          end
          if (in_acc && (sos_mode_e'(mode_i) == MODE_TRIM) && (value_i == 32'd0)) begin
            act_q <= '0;
            cnt_q <= '0;
          end
        end
        ST_CLR: begin
          sweep_q <= sweep_q + AW'(1);
          if (sweep_last) begin
            act_q <= len_clamped;
            cnt_q <= len_clamped;
          end
        end
        ST_MCHK: begin
          if (~ram_rdata && (cnt_q != '0)) begin
            cnt_q <= cnt_q - LW'(1);
          end
        end
        ST_TCHK: begin
          if (~ram_rdata && ((32'(seen_q) + 32'd1) == val_q)) begin
            act_q <= LW'(idx_q + 33'd1);
            cnt_q <= LW'(val_q);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers; the controller state decides when each one loads.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          val_q       <= value_i;
          mode_q      <= mode_i;
          eor_q       <= end_of_run_i;
          idx_q       <= '0;
          seen_q      <= '0;
          res_idx_q   <= value_i[AW-1:0];
          res_hit_q   <= 1'b0;
          res_prime_q <= 1'b0;
          res_stat_q  <= ((sos_mode_e'(mode_i) == MODE_PROBE) && (value_i >= 32'(act_q)))
                         ? STAT_RANGE : STAT_OK;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          idx_q <= first_off;
        end
      end
      ST_MCHK: idx_q <= idx_q + {1'b0, val_q};
      ST_PCHK: begin
        res_hit_q   <= 1'b1;
        res_prime_q <= ~ram_rdata;
      end
      ST_TRD: begin
        if (!idx_in) begin
          res_stat_q <= STAT_SHORT;
        end
      end
      ST_TCHK: begin
        if (~ram_rdata) begin
          seen_q <= seen_q + LW'(1);
          if ((32'(seen_q) + 32'd1) == val_q) begin
            res_hit_q   <= 1'b1;
            res_prime_q <= 1'b1;
            res_idx_q   <= idx_q[AW-1:0];
          end
        end
        idx_q <= idx_q + 33'd1;
      end
      default: ;
    endcase
  end

  // Output register: holds a finished result while the receiver stalls.
  logic out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      prime_count_o  <= 13'(cnt_q);
      found_index_o  <= res_hit_q ? 12'(res_idx_q) : 12'd0;
      found_number_o <= res_hit_q ? ((seg_start_q | 32'd1) + 32'({res_idx_q, 1'b0}))
                                  : 32'd0;
      is_prime_o     <= res_hit_q & res_prime_q;
      run_done_o     <= (sos_mode_e'(mode_q) == MODE_MARK) & eor_q;
      status_o       <= res_stat_q;
    end
  end

`ifndef SYNTHESIS
  // The count of unmarked entries never exceeds the active length.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= act_q)
    else $error("unmarked count above active length");

  // A finished result is held in the final state while the output is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && out_valid_q && out_stall_i |=> state_q == ST_FIN)
    else $error("result dropped while receiver stalls");

  // The divider only reports completion while the controller waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == ST_DIV)
    else $error("divider finished outside the division state");
`endif

endmodule
